/* hdl/sceb_pkg.sv */
// ----------------------------------------------------------------------------
// Sync-counter event builder package
// Shared sizes, codes, controller/datapath command and status types, and
// address helpers for the per-source frame FIFOs.
// ----------------------------------------------------------------------------
package sceb_pkg;

  // Storage geometry
  localparam int NUM_SOURCES = 4;
  localparam int FIFO_DEPTH  = 16;
  localparam int MEM_DEPTH   = NUM_SOURCES * FIFO_DEPTH;

  localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int NS_W   = $clog2(NUM_SOURCES + 1);
  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // Field widths
  localparam int SRC_FIELD_W = 2;
  localparam int SYNC_W      = 9;
  localparam int PAY_W       = 16;
  localparam int WORD_W      = SYNC_W + PAY_W + 1;
  localparam int SYNC_HALF   = 256;

  // Configuration port
  localparam int ACT_W      = 3;
  localparam int OCC_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OCC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OCC = 2'd2;

  localparam logic [ACT_W-1:0] ACTIVE_RST  = 3'd1;
  localparam logic [OCC_W-1:0] MIN_OCC_RST = 5'd1;
  localparam logic [OCC_W-1:0] MAX_OCC_RST = 5'd8;

  // Item and result codes
  localparam logic OP_PUSH     = 1'b0;
  localparam logic OP_POLL     = 1'b1;
  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic             capture;      // latch the accepted input item
    logic             push_write;   // store the frame, advance write side
    logic             load_reject;  // put a rejection in the output register
    logic             rd_issue;     // read the head frame of source idx
    logic             calc_low;     // resolve the lowest head counter
    logic             emit;         // put the entry of source idx out, pop on match
    logic [SRC_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic src_ok;     // pushed source exists
    logic push_full;  // its FIFO is full
    logic build_ok;   // build condition holds
    logic last_src;   // idx is the last active source
    logic out_free;   // output register can take a result
  } sts_t;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] ram_addr(logic [SRC_W-1:0] s, logic [PTR_W-1:0] p);
    return ADDR_W'(ADDR_W'(s) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(p));
  endfunction

endpackage

/* hdl/sceb_ifs.sv */
// ----------------------------------------------------------------------------
// Sync-counter event builder channels
// Valid/ready interfaces for the item, result and configuration channels.
// ----------------------------------------------------------------------------
interface sceb_in_if;
  import sceb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [SRC_FIELD_W-1:0] source_index;
  logic [SYNC_W-1:0]      sync_count;
  logic [PAY_W-1:0]       payload_tag;
  logic                   frame_ok;

  modport source (output valid, operation, source_index, sync_count, payload_tag,
                  frame_ok, input ready);
  modport sink   (input valid, operation, source_index, sync_count, payload_tag,
                  frame_ok, output ready);
endinterface

interface sceb_out_if;
  import sceb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [SRC_FIELD_W-1:0] entry_source;
  logic [SYNC_W-1:0]      entry_sync;
  logic [PAY_W-1:0]       entry_payload;
  logic                   entry_ok;
  logic                   last_entry;

  modport source (output valid, kind, entry_source, entry_sync, entry_payload, entry_ok,
                  last_entry, input ready);
  modport sink   (input valid, kind, entry_source, entry_sync, entry_payload, entry_ok,
                  last_entry, output ready);
endinterface

interface sceb_cfg_if;
  import sceb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/sync_counter_event_builder.sv */
// ----------------------------------------------------------------------------
// Sync-counter event builder
// Per-source frame FIFOs aligned on a 9-bit wrapping sync counter.
// ----------------------------------------------------------------------------
// Channels: in_ch takes push items (queue a frame into a source FIFO) and
// poll items (build check only); out_ch delivers event entries and push
// rejections; cfg_ch writes active_sources, min_occupancy, max_occupancy.
// All are valid/ready; a transfer happens when both are high at a clock edge.
// One item is worked at a time. A poll goes straight to the build check; a
// push first stores its frame. A build reads the head frames one per cycle
// through the single read port of the frame store; a drain step takes the
// last read and a low step resolves the lowest counter, then one entry per
// active source goes out, one per cycle while the receiver does not stall.
// A finished result waits in the output register; the next item is taken
// meanwhile, and the controller holds only when it has another result to
// place while the receiver stalls.
// Reset (synchronous, rst_n low) empties all FIFOs and restores the register
// defaults; no clearing pass over the frame store is needed.
// ----------------------------------------------------------------------------
module sync_counter_event_builder (
  input  logic      clk,
  input  logic      rst_n,
  sceb_in_if.sink   in_ch,
  sceb_out_if.source out_ch,
  sceb_cfg_if.sink  cfg_ch
);
  import sceb_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ready_w;

  sceb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (ready_w),
    .cmd          (cmd),
    .sts          (sts)
  );

  assign in_ch.ready = ready_w;

  sceb_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_source_index (in_ch.source_index),
    .in_sync_count   (in_ch.sync_count),
    .in_payload_tag  (in_ch.payload_tag),
    .in_frame_ok     (in_ch.frame_ok),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch)
  );

endmodule

/* hdl/sceb_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sceb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/sceb_datapath.sv */
// ----------------------------------------------------------------------------
// Sync-counter event builder datapath
// Config registers, FIFO pointers and fill counts, frame store, head capture
// with running min/max, lowest-counter resolution and the output register.
// ----------------------------------------------------------------------------
module sceb_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sceb_pkg::cmd_t                   cmd,
  output sceb_pkg::sts_t                   sts,
  input  logic                             in_operation,
  input  logic [sceb_pkg::SRC_FIELD_W-1:0] in_source_index,
  input  logic [sceb_pkg::SYNC_W-1:0]      in_sync_count,
  input  logic [sceb_pkg::PAY_W-1:0]       in_payload_tag,
  input  logic                             in_frame_ok,
  sceb_out_if.source                       out_ch,
  sceb_cfg_if.sink                         cfg_ch
);
  import sceb_pkg::*;

  // Configuration
  logic [ACT_W-1:0] active_r;
  logic [OCC_W-1:0] min_occ_r;
  logic [OCC_W-1:0] max_occ_r;
  logic [NS_W-1:0]  n_eff;

  // FIFO bookkeeping
  logic [CNT_W-1:0] fill_r [NUM_SOURCES];
  logic [PTR_W-1:0] rdp_r  [NUM_SOURCES];
  logic [PTR_W-1:0] wrp_r  [NUM_SOURCES];

  // Latched item
  logic                   op_r;
  logic [SRC_FIELD_W-1:0] src_r;
  logic [SYNC_W-1:0]      sync_r;
  logic [PAY_W-1:0]       pay_r;
  logic                   ok_r;
  logic [SRC_W-1:0]       src_idx;

  // Head capture
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  head_r [NUM_SOURCES];
  logic               cap_vld_r;
  logic [SRC_W-1:0]   cap_idx_r;
  logic [SYNC_W-1:0]  cap_sync;
  logic signed [SYNC_W:0] cap_wrap;
  logic [SYNC_W-1:0]  min1_r, max1_r;
  logic signed [SYNC_W:0] min2_r, max2_r;
  logic [SYNC_W:0]    span1, span2;
  logic [SYNC_W-1:0]  low_r;

  // Emit path
  logic [WORD_W-1:0]  emit_word;
  logic [SYNC_W-1:0]  emit_sync;
  logic               emit_match;

  // Output register
  logic                   out_vld_r;
  logic                   out_kind_r;
  logic [SRC_FIELD_W-1:0] out_src_r;
  logic [SYNC_W-1:0]      out_sync_r;
  logic [PAY_W-1:0]       out_pay_r;
  logic                   out_ok_r;
  logic                   out_last_r;

  logic all_nonempty, any_over, all_min;

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= ACTIVE_RST;
      min_occ_r <= MIN_OCC_RST;
      max_occ_r <= MAX_OCC_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ACTIVE:  active_r  <= cfg_ch.data[ACT_W-1:0];
        REG_MIN_OCC: min_occ_r <= cfg_ch.data[OCC_W-1:0];
        REG_MAX_OCC: max_occ_r <= cfg_ch.data[OCC_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate to the number of FIFOs present
  assign n_eff = (32'(active_r) > NUM_SOURCES) ? NS_W'(NUM_SOURCES) : NS_W'(active_r);

  // ---------------- item latch ----------------
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      src_r  <= in_source_index;
      sync_r <= in_sync_count;
      pay_r  <= in_payload_tag;
      ok_r   <= in_frame_ok;
    end
  end

  assign src_idx = SRC_W'(src_r);

  // ---------------- status ----------------
  always_comb begin
    all_nonempty = 1'b1;
    any_over     = 1'b0;
    all_min      = 1'b1;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      if (s < 32'(n_eff)) begin
        if (fill_r[s] == '0) all_nonempty = 1'b0;
        if (32'(fill_r[s]) > 32'(max_occ_r)) any_over = 1'b1;
        if (32'(fill_r[s]) < 32'(min_occ_r)) all_min = 1'b0;
      end
    end
  end

  always_comb begin
    sts.src_ok    = (32'(src_r) < NUM_SOURCES) && (op_r == OP_PUSH);
    sts.push_full = (fill_r[src_idx] == CNT_W'(FIFO_DEPTH));
    sts.build_ok  = (n_eff != '0) && all_nonempty && (any_over || all_min);
    sts.last_src  = (32'(cmd.idx) == 32'(n_eff) - 1);
    sts.out_free  = !out_vld_r || out_ch.ready;
  end

  // ---------------- frame store ----------------
  sceb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.push_write),
    .waddr (ram_addr(src_idx, wrp_r[src_idx])),
    .wdata ({sync_r, pay_r, ok_r}),
    .re    (cmd.rd_issue),
    .raddr (ram_addr(cmd.idx, rdp_r[cmd.idx])),
    .rdata (rd_data)
  );

  // ---------------- emit decode ----------------
  assign emit_word  = head_r[cmd.idx];
  assign emit_sync  = emit_word[WORD_W-1 -: SYNC_W];
  assign emit_match = (emit_sync == low_r);

  // ---------------- pointers and fill counts ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        fill_r[s] <= '0;
        rdp_r[s]  <= '0;
        wrp_r[s]  <= '0;
      end
    end else begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        if (cmd.push_write && (32'(src_idx) == s)) begin
          wrp_r[s]  <= next_ptr(wrp_r[s]);
          fill_r[s] <= CNT_W'(fill_r[s] + 1'b1);
        end else if (cmd.emit && emit_match && (32'(cmd.idx) == s)) begin
          rdp_r[s]  <= next_ptr(rdp_r[s]);
          fill_r[s] <= CNT_W'(fill_r[s] - 1'b1);
        end
      end
    end
  end

  // ---------------- head capture, running min/max ----------------
  assign cap_sync = rd_data[WORD_W-1 -: SYNC_W];
  // counters above half the wrap count as negative
  assign cap_wrap = (cap_sync > SYNC_W'(SYNC_HALF)) ? $signed({1'b1, cap_sync})
                                                   : $signed({1'b0, cap_sync});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_vld_r <= 1'b0;
    end else begin
      cap_vld_r <= cmd.rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    cap_idx_r <= cmd.idx;
    if (cap_vld_r) begin
      head_r[cap_idx_r] <= rd_data;
      if (cap_idx_r == '0) begin
        min1_r <= cap_sync;
        max1_r <= cap_sync;
        min2_r <= cap_wrap;
        max2_r <= cap_wrap;
      end else begin
        if (cap_sync < min1_r) min1_r <= cap_sync;
        if (cap_sync > max1_r) max1_r <= cap_sync;
        if (cap_wrap < min2_r) min2_r <= cap_wrap;
        if (cap_wrap > max2_r) max2_r <= cap_wrap;
      end
    end
  end

  // pick the reading (plain or wrapped) with the smaller spread
  assign span1 = {1'b0, max1_r} - {1'b0, min1_r};
  assign span2 = (SYNC_W+1)'(max2_r - min2_r);

  always_ff @(posedge clk) begin
    if (cmd.calc_low) begin
      low_r <= (span1 < span2) ? min1_r : min2_r[SYNC_W-1:0];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_reject || cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_reject) begin
      out_kind_r <= KIND_REJECT;
      out_src_r  <= src_r;
      out_sync_r <= sync_r;
      out_pay_r  <= pay_r;
      out_ok_r   <= ok_r;
      out_last_r <= 1'b0;
    end else if (cmd.emit) begin
      out_kind_r <= KIND_ENTRY;
      out_src_r  <= SRC_FIELD_W'(cmd.idx);
      out_sync_r <= emit_sync;
      out_pay_r  <= emit_word[PAY_W:1];
      out_ok_r   <= emit_word[0] & emit_match;
      out_last_r <= sts.last_src;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.entry_source  = out_src_r;
  assign out_ch.entry_sync    = out_sync_r;
  assign out_ch.entry_payload = out_pay_r;
  assign out_ch.entry_ok      = out_ok_r;
  assign out_ch.last_entry    = out_last_r;

  // ---------------- assertions ----------------
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_write |-> (32'(fill_r[src_idx]) < FIFO_DEPTH))
    else $error("push into a full FIFO");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.load_reject) |-> sts.out_free)
    else $error("output register overwritten while a result waits");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_reject |-> (sts.push_full && sts.src_ok))
    else $error("rejection without a full FIFO");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (!cmd.emit && !cmd.push_write))
    else $error("head read overlaps a FIFO update");

endmodule

/* hdl/sceb_ctrl.sv */
// ----------------------------------------------------------------------------
// Sync-counter event builder controller
// Sequences push, build check, head reads, lowest-counter resolution and
// entry emission; commands the datapath one step at a time.
// ----------------------------------------------------------------------------
module sceb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_operation,
  output logic           in_ready,
  output sceb_pkg::cmd_t cmd,
  input  sceb_pkg::sts_t sts
);
  import sceb_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PUSH  = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_READ  = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_LOW   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [SRC_W-1:0] idx_r, idx_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_operation == OP_PUSH) ? ST_PUSH : ST_CHECK;
        end
      end
      ST_PUSH: begin
        if (!sts.src_ok) begin
          state_nxt = ST_CHECK;
        end else if (sts.push_full) begin
          // hold until the output register frees up
          if (sts.out_free) begin
            cmd.load_reject = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else begin
          cmd.push_write = 1'b1;
          state_nxt      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        idx_nxt   = '0;
        state_nxt = sts.build_ok ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.last_src) begin
          idx_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = SRC_W'(idx_r + 1'b1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_LOW;
      end
      ST_LOW: begin
        cmd.calc_low = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_src) begin
            idx_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = SRC_W'(idx_r + 1'b1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
